/* hw/rtl/subset_sum_reachability_top_macros.svh */
// assertion macros used by subset_sum_reachability_top
`ifndef SUBSET_SUM_REACHABILITY_TOP_MACROS_SVH
`define SUBSET_SUM_REACHABILITY_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SSR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define SSR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/ssr_pkg.sv */
package ssr_pkg;

	// width of every numeric field on the ports
	localparam int unsigned FIELD_W = 17;
	localparam int unsigned CMD_W   = 2;

	// default largest sum the bitmap holds
	localparam int unsigned MAX_SUM_DEF = 131071;

	// command codes
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_NEXT  = 2'd2;

	// one command transfer
	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [FIELD_W-1:0] coin_value;
	} cmd_t;

	// one result transfer
	typedef struct packed {
		logic [FIELD_W-1:0] reachable_count;
		logic [FIELD_W-1:0] sum_value;
		logic               found;
		logic               overflow;
	} result_t;

endpackage

/* hw/rtl/subset_sum_reachability_top.sv */
// Subset-sum reachability engine. A command transfers at a clock edge with start high and
// busy low; exactly one result follows, shown on result for a single cycle while done is
// high, and must be captured then. The reachable-sum bitmap lives in a one-write, two-read
// synchronous RAM of MAX_SUM+1 bits; a command that walks it visits one entry per clock.
// After reset and after a clear command the block sweeps the whole bitmap, all MAX_SUM+1
// entries (131072 at the default), before it takes the next command; a clear then passes
// through the reply state and returns its result. An add of coin c with saturated total T
// walks the entries from T down to c; a zero coin or one above MAX_SUM goes straight to
// the reply. A read-next walks up from just past the cursor to the found sum (or the coin
// total). Command code three and a read whose cursor already sits at the coin total go
// straight to the reply.
module subset_sum_reachability_top
	import ssr_pkg::*;
#(
	parameter int unsigned MAX_SUM = MAX_SUM_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  cmd_t    cmd,
	output logic    busy,
	output logic    done,
	output result_t result
);

	`include "subset_sum_reachability_top_macros.svh"

	localparam int unsigned AW = $clog2(MAX_SUM + 1);
	localparam int unsigned SW = ((AW > FIELD_W) ? AW : FIELD_W) + 1;
	localparam logic [AW-1:0] MAX_A = AW'(MAX_SUM);
	localparam logic [SW-1:0] MAX_S = SW'(MAX_SUM);

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_INIT  = 3'd1;
	localparam logic [2:0] ST_ADD   = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_REPLY = 3'd4;

	logic [2:0]    state_q;
	logic [AW-1:0] ptr_q;
	logic [AW-1:0] end_q;
	logic          iss_q;
	logic [AW-1:0] coin_q;
	logic [AW-1:0] total_q;
	logic [AW-1:0] count_q;
	logic [AW-1:0] cursor_q;
	logic          ovf_q;
	logic [AW-1:0] sum_q;
	logic          found_q;
	logic          clr_reply_q;
	logic          done_q;
	result_t       result_q;

	logic          valid_s1;
	logic          last_s1;
	logic [AW-1:0] addr_s1;

	logic          rd_bit_a;
	logic          rd_bit_b;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic          wr_bit;
	logic          new_sum;

	logic          accept;
	logic [SW-1:0] coin_w;
	logic [SW-1:0] raw_total;
	logic [AW-1:0] sat_total;
	logic          coin_ok;
	logic          last_iss;

	// bitmap storage
	ssr_bitmap #(
		.DEPTH (MAX_SUM + 1),
		.AW    (AW)
	) u_bitmap (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_bit    (wr_bit),
		.rd_addr_a (ptr_q),
		.rd_addr_b (ptr_q - coin_q),
		.rd_bit_a  (rd_bit_a),
		.rd_bit_b  (rd_bit_b)
	);

	// command decode helpers
	assign accept    = start && (state_q == ST_IDLE);
	assign coin_w    = SW'(cmd.coin_value);
	assign raw_total = SW'(total_q) + coin_w;
	assign sat_total = (raw_total > MAX_S) ? MAX_A : AW'(raw_total);
	assign coin_ok   = (cmd.coin_value != '0) && (coin_w <= MAX_S);
	assign last_iss  = (ptr_q == end_q);

	// a sum becomes reachable when s is clear and s - coin was set before this coin
	assign new_sum = (state_q == ST_ADD) && valid_s1 && !rd_bit_a && rd_bit_b;

	// write port: clearing sweep or read-modify-write of the add pass
	always_comb begin
		if (state_q == ST_INIT) begin
			wr_en   = 1'b1;
			wr_addr = ptr_q;
			wr_bit  = (ptr_q == '0);
		end else begin
			wr_en   = new_sum;
			wr_addr = addr_s1;
			wr_bit  = 1'b1;
		end
	end

	// read stage: the issued address and its flags, registered to line up with the RAM read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			addr_s1  <= '0;
		end else begin
			valid_s1 <= ((state_q == ST_ADD) || (state_q == ST_SCAN)) && iss_q;
			last_s1  <= last_iss;
			addr_s1  <= ptr_q;
		end
	end

	// sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			ptr_q       <= '0;
			end_q       <= MAX_A;
			iss_q       <= 1'b0;
			coin_q      <= '0;
			total_q     <= '0;
			count_q     <= '0;
			cursor_q    <= '0;
			ovf_q       <= 1'b0;
			sum_q       <= '0;
			found_q     <= 1'b0;
			clr_reply_q <= 1'b0;
			done_q      <= 1'b0;
			result_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						sum_q   <= '0;
						found_q <= 1'b0;
						case (cmd.command)
							CMD_CLEAR: begin
								total_q     <= '0;
								count_q     <= '0;
								cursor_q    <= '0;
								ovf_q       <= 1'b0;
								ptr_q       <= '0;
								end_q       <= MAX_A;
								clr_reply_q <= 1'b1;
								state_q     <= ST_INIT;
							end
							CMD_ADD: begin
								total_q <= sat_total;
								if (raw_total > MAX_S) begin
									ovf_q <= 1'b1;
								end
								if (coin_ok) begin
									coin_q  <= AW'(cmd.coin_value);
									ptr_q   <= sat_total;
									end_q   <= AW'(cmd.coin_value);
									iss_q   <= 1'b1;
									state_q <= ST_ADD;
								end else begin
									state_q <= ST_REPLY;
								end
							end
							CMD_NEXT: begin
								if (cursor_q < total_q) begin
									ptr_q   <= cursor_q + 1'b1;
									end_q   <= total_q;
									iss_q   <= 1'b1;
									state_q <= ST_SCAN;
								end else begin
									state_q <= ST_REPLY;
								end
							end
							default: begin
								state_q <= ST_REPLY;
							end
						endcase
					end
				end
				ST_INIT: begin
					ptr_q <= ptr_q + 1'b1;
					if (last_iss) begin
						state_q <= clr_reply_q ? ST_REPLY : ST_IDLE;
					end
				end
				ST_ADD: begin
					// walk down from the saturated total to the coin value
					if (iss_q) begin
						ptr_q <= ptr_q - 1'b1;
						if (last_iss) begin
							iss_q <= 1'b0;
						end
					end
					if (new_sum) begin
						count_q <= count_q + 1'b1;
					end
					if (valid_s1 && last_s1) begin
						state_q <= ST_REPLY;
					end
				end
				ST_SCAN: begin
					// walk up from just past the cursor, stop at the first set bit or the coin total
					if (iss_q) begin
						ptr_q <= ptr_q + 1'b1;
						if (last_iss) begin
							iss_q <= 1'b0;
						end
					end
					if (valid_s1 && rd_bit_a) begin
						sum_q    <= addr_s1;
						found_q  <= 1'b1;
						cursor_q <= addr_s1;
						iss_q    <= 1'b0;
						state_q  <= ST_REPLY;
					end else if (valid_s1 && last_s1) begin
						state_q <= ST_REPLY;
					end
				end
				ST_REPLY: begin
					done_q                   <= 1'b1;
					result_q.reachable_count <= FIELD_W'(count_q);
					result_q.sum_value       <= FIELD_W'(sum_q);
					result_q.found           <= found_q;
					result_q.overflow        <= ovf_q;
					state_q                  <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// checks
	`SSR_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted command did not raise busy")
	`SSR_ASSERT_NOW(a_done_idle, done_q, !busy, "result shown while still busy")
	`SSR_ASSERT_NOW(a_count_le_total, 1'b1, count_q <= total_q,
		"distinct count exceeds coin total")
	`SSR_ASSERT_NOW(a_add_wr_range, new_sum, (wr_addr >= coin_q) && (wr_addr <= total_q),
		"add pass wrote outside coin..total")
	`SSR_ASSERT_NOW(a_found_cursor, (state_q == ST_REPLY) && found_q,
		(sum_q != '0) && (sum_q == cursor_q), "found sum does not match cursor")

endmodule

/* hw/rtl/ssr_bitmap.sv */
module ssr_bitmap #(
	parameter int unsigned DEPTH = 131072,
	parameter int unsigned AW    = 17
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic          wr_bit,
	input  logic [AW-1:0] rd_addr_a,
	input  logic [AW-1:0] rd_addr_b,
	output logic          rd_bit_a,
	output logic          rd_bit_b
);

	// reachability bits, one per sum
	logic mem [DEPTH];

	// single write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_bit;
		end
	end

	// two registered read ports
	always_ff @(posedge clk) begin
		rd_bit_a <= mem[rd_addr_a];
		rd_bit_b <= mem[rd_addr_b];
	end

endmodule

/* bench/subset_sum_checker.sv */
`timescale 1ns / 100ps

module subset_sum_checker
	import ssr_pkg::*;
#(
	parameter int unsigned MAX_SUM = MAX_SUM_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  cmd_t        cmd,
	input  logic        busy,
	input  logic        done,
	input  result_t     result,
	output int unsigned fail_count,
	output int unsigned pending,
	output int unsigned checked_count
);

	// predicted contents of the block
	bit          reach_map [0:MAX_SUM];
	int unsigned coin_total;
	int unsigned distinct_count;
	int unsigned scan_cursor;
	bit          overflow_seen;

	result_t     expected_results[$];
	result_t     want;
	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned compared;

	assign fail_count    = mismatches;
	assign pending       = outstanding;
	assign checked_count = compared;

	// back to the empty subset only
	function automatic void clear_sums();
		foreach (reach_map[i])
			reach_map[i] = 1'b0;
		reach_map[0]   = 1'b1;
		coin_total     = 0;
		distinct_count = 0;
		scan_cursor    = 0;
		overflow_seen  = 1'b0;
	endfunction

	// apply one command and return the result it should produce
	function automatic result_t apply_command(cmd_t c);
		result_t     r;
		int unsigned coin;
		int unsigned upper;
		int unsigned s;
		r    = '0;
		coin = 32'(c.coin_value);
		case (c.command)
			CMD_CLEAR: begin
				clear_sums();
			end
			CMD_ADD: begin
				// nothing above the old total is reachable yet
				upper = coin_total + coin;
				if (upper > MAX_SUM) begin
					upper         = MAX_SUM;
					overflow_seen = 1'b1;
				end
				coin_total = upper;
				if (coin != 0 && coin <= MAX_SUM) begin
					// high to low so the coin is used once
					for (s = upper; s >= coin; s--) begin
						if (!reach_map[s] && reach_map[s - coin]) begin
							reach_map[s]   = 1'b1;
							distinct_count = distinct_count + 1;
						end
					end
				end
			end
			CMD_NEXT: begin
				for (s = scan_cursor + 1; s <= MAX_SUM && !r.found; s++) begin
					if (reach_map[s]) begin
						r.found     = 1'b1;
						r.sum_value = s[FIELD_W-1:0];
						scan_cursor = s;
					end
				end
			end
			default: ;
		endcase
		r.reachable_count = distinct_count[FIELD_W-1:0];
		r.overflow        = overflow_seen;
		return r;
	endfunction

	// compare each result transfer, then record the next command transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_sums();
			expected_results.delete();
			mismatches  = 0;
			outstanding = 0;
			compared    = 0;
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("unexpected result: cnt=%0d sum=%0d fnd=%0b ovf=%0b",
							result.reachable_count, result.sum_value,
							result.found, result.overflow);
				end else begin
					want     = expected_results.pop_front();
					compared = compared + 1;
					if (result !== want) begin
						mismatches = mismatches + 1;
						if (mismatches <= 10) begin
							$display("mismatch: exp cnt=%0d sum=%0d fnd=%0b ovf=%0b",
								want.reachable_count, want.sum_value, want.found,
								want.overflow);
							$display("          got cnt=%0d sum=%0d fnd=%0b ovf=%0b",
								result.reachable_count, result.sum_value,
								result.found, result.overflow);
						end
					end
				end
			end
			if (start && !busy)
				expected_results.insert(expected_results.size(), apply_command(cmd));
			outstanding = expected_results.size();
		end
	end

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
	import ssr_pkg::*;

	// the one code the block leaves unused
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	cmd_t        cmd;
	logic        busy;
	logic        done;
	result_t     result;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned checked_count;

	int unsigned n_add;
	int unsigned n_read;
	int unsigned n_clear;
	int unsigned n_unused;

	subset_sum_reachability_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	subset_sum_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.cmd           (cmd),
		.busy          (busy),
		.done          (done),
		.result        (result),
		.fail_count    (fail_count),
		.pending       (pending),
		.checked_count (checked_count)
	);

	// 10 ns clock
	always #5 clk = ~clk;

	// mostly short idle gaps, a few long ones, none inside a burst
	function automatic int unsigned pick_gap(bit burst);
		int unsigned r;
		if (burst)
			return 0;
		r = $urandom_range(0, 9);
		if (r < 5)
			return 0;
		else if (r < 9)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// one command transfer, then an optional idle gap
	task automatic issue(input logic [CMD_W-1:0] op, input logic [FIELD_W-1:0] coin,
		input int unsigned gap);
		start <= 1'b1;
		cmd   <= '{command: op, coin_value: coin};
		do
			@(posedge clk);
		while (busy);
		case (op)
			CMD_CLEAR: n_clear++;
			CMD_ADD:   n_add++;
			CMD_NEXT:  n_read++;
			default:   n_unused++;
		endcase
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// run limit
	initial begin
		#(200_000_000);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int unsigned i;
		int unsigned r;
		bit          burst;
		n_add    = 0;
		n_read   = 0;
		n_clear  = 0;
		n_unused = 0;
		start  <= 1'b0;
		cmd    <= '0;
		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty bitmap: read finds nothing, unused code, zero coin
		issue(CMD_NEXT, '0, pick_gap(0));
		issue(CMD_UNUSED, 17'h1ffff, pick_gap(0));
		issue(CMD_ADD, '0, pick_gap(0));

		// small coins with a repeat, then walk the list past its end
		issue(CMD_ADD, 17'd3, pick_gap(0));
		issue(CMD_ADD, 17'd5, pick_gap(0));
		issue(CMD_ADD, 17'd3, pick_gap(0));
		repeat (6) issue(CMD_NEXT, '0, pick_gap(0));

		// huge coins: total saturates, sums past capacity are dropped
		issue(CMD_ADD, 17'd131070, pick_gap(0));
		issue(CMD_ADD, 17'h1ffff, pick_gap(0));
		issue(CMD_UNUSED, '0, pick_gap(0));
		repeat (3) issue(CMD_NEXT, 17'h1ffff, pick_gap(0));

		// clear drops everything, including the overflow flag
		issue(CMD_CLEAR, 17'h15555, pick_gap(0));
		issue(CMD_NEXT, '0, pick_gap(0));
		issue(CMD_ADD, 17'd1, pick_gap(0));
		issue(CMD_ADD, 17'd2, pick_gap(0));

		// random mix of coins, reads and unused codes with one clear midway
		for (i = 0; i < 80; i++) begin
			burst = (i >= 60 && i < 76);
			if (i == 50) begin
				issue(CMD_CLEAR, 17'($urandom), pick_gap(burst));
			end else begin
				r = $urandom_range(0, 99);
				if (r < 50) begin
					if ($urandom_range(0, 19) == 0)
						issue(CMD_ADD, 17'($urandom_range(100, 600)), pick_gap(burst));
					else
						issue(CMD_ADD, 17'($urandom_range(0, 48)), pick_gap(burst));
				end else if (r < 94) begin
					issue(CMD_NEXT, 17'($urandom), pick_gap(burst));
				end else begin
					issue(CMD_UNUSED, 17'($urandom), pick_gap(burst));
				end
			end
		end
		start <= 1'b0;

		// drain the remaining results
		@(posedge clk);
		wait (pending == 0);
		repeat (20) @(posedge clk);

		$display("covered %0d commands: %0d adds, %0d reads, %0d clears, %0d unused codes",
			n_add + n_read + n_clear + n_unused, n_add, n_read, n_clear, n_unused);
		$display("%0d results compared, including overflow and top-of-range sums",
			checked_count);
		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
